/* rtl/assert_macros.svh */
// Assertion macros shared by the rasterizer modules.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%s", "lbl");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("never");
`endif

/* rtl/osr_pkg.sv */
// Package for the outline shape rasterizer: canvas sizes, request kinds and types.
// Depends on nothing.
package osr_pkg;
  localparam int CanvasWidth  = 80;
  localparam int CanvasHeight = 24;
  localparam int CanvasDepth  = CanvasWidth * CanvasHeight;
  localparam int AddrW        = $clog2(CanvasDepth);
  localparam int QueueDepth   = 2;

  typedef enum logic [2:0] {
    KindClear = 3'd0, KindLine = 3'd1, KindRect = 3'd2,
    KindTri = 3'd3, KindCircle = 3'd4, KindRead = 3'd5,
    KindSpare6 = 3'd6, KindSpare7 = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] ax;
    logic [4:0] ay;
    logic [6:0] bx;
    logic [4:0] by;
    logic [6:0] cx;
    logic [4:0] cy;
    logic [6:0] w;
    logic [4:0] h;
    logic [6:0] r;
  } req_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StSeg, StRect, StCircInit, StCircPlot, StCircStep,
    StRead, StReadWait, StDone
  } back_state_e;

  // Plot request from the shape walker into the canvas port.
  typedef struct packed {
    logic              valid;
    logic signed [11:0] x;
    logic signed [11:0] y;
  } plot_t;
endpackage

/* rtl/osr_front.sv */
// Front part: takes requests and queues them for the drawing engine.
// Depends on osr_pkg and assert_macros.svh.
module osr_front
  import osr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output req_t head_o
);
  req_t       mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(QueueDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'(QueueDepth))
endmodule

/* rtl/osr_back.sv */
// Back part: walks shapes, plotting at most one pixel per cycle, and owns the canvas memory.
// Depends on osr_pkg and assert_macros.svh.
module osr_back
  import osr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  req_t       req_i,
  output logic       pop_o,
  output logic       res_o,
  output logic       pix_o,
  output kind_e      kind_o
);
  typedef logic signed [11:0] crd_t;

  back_state_e st_q, st_d;
  req_t        cur_q, cur_d;
  crd_t        x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  crd_t        dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic        sx_q, sx_d, sy_q, sy_d;
  logic [1:0]  seg_q, seg_d;
  crd_t        i_q, i_d;
  logic [2:0]  oct_q, oct_d;
  crd_t        cxo_q, cxo_d, cyo_q, cyo_d, dd_q, dd_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic        res_q, res_d, pix_q;
  kind_e       kind_q, kind_d;
  plot_t       plot;
  logic        mem_we, mem_wd;
  logic [AddrW-1:0] mem_a;
  logic        mem [CanvasDepth];
  logic        rd_q;
  logic        rd_ok_q, rd_ok_d;
  logic        first_q;

  assign res_o  = res_q;
  assign pix_o  = pix_q;
  assign kind_o = kind_q;

  function automatic logic signed [11:0] seg_abs(input logic signed [11:0] v);
    return v[11] ? -v : v;
  endfunction

  always_comb begin
    plot = '0;
    st_d = st_q; cur_d = cur_q;
    x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    dx_d = dx_q; dy_d = dy_q; err_d = err_q; sx_d = sx_q; sy_d = sy_q;
    seg_d = seg_q; i_d = i_q; oct_d = oct_q; cxo_d = cxo_q; cyo_d = cyo_q; dd_d = dd_q;
    clr_d = clr_q; res_d = 1'b0; kind_d = kind_q; pop_o = 1'b0;
    rd_ok_d = rd_ok_q;
    mem_we = 1'b0; mem_wd = 1'b1; mem_a = '0;
    unique case (st_q)
      StIdle: begin
        if (avail_i) begin
          pop_o = 1'b1;
          cur_d = req_i;
          seg_d = 2'd0;
          i_d = '0;
          clr_d = '0;
          x0_d = crd_t'(req_i.ax); y0_d = crd_t'(req_i.ay);
          x1_d = crd_t'(req_i.bx); y1_d = crd_t'(req_i.by);
          unique case (req_i.kind)
            KindClear:  st_d = StClear;
            KindLine, KindTri: st_d = StSeg;
            KindRect:   st_d = StRect;
            KindCircle: st_d = StCircInit;
            KindRead:   st_d = StRead;
            default:    st_d = StDone;
          endcase
          dx_d = seg_abs(crd_t'(req_i.bx) - crd_t'(req_i.ax));
          dy_d = seg_abs(crd_t'(req_i.by) - crd_t'(req_i.ay));
          sx_d = (req_i.ax < req_i.bx);
          sy_d = (req_i.ay < req_i.by);
          err_d = seg_abs(crd_t'(req_i.bx) - crd_t'(req_i.ax))
                - seg_abs(crd_t'(req_i.by) - crd_t'(req_i.ay));
        end
      end
      StClear: begin
        mem_we = 1'b1; mem_wd = 1'b0; mem_a = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(CanvasDepth - 1)) st_d = first_q ? StIdle : StDone;
      end
      StSeg: begin
        plot.valid = 1'b1; plot.x = x0_q; plot.y = y0_q;
        if (x0_q == x1_q && y0_q == y1_q) begin
          if (cur_q.kind == KindTri && seg_q != 2'd2) begin
            seg_d = seg_q + 2'd1;
            x0_d = x1_q; y0_d = y1_q;
            x1_d = (seg_q == 2'd0) ? crd_t'(cur_q.cx) : crd_t'(cur_q.ax);
            y1_d = (seg_q == 2'd0) ? crd_t'(cur_q.cy) : crd_t'(cur_q.ay);
            dx_d = seg_abs(x1_d - x1_q);
            dy_d = seg_abs(y1_d - y1_q);
            sx_d = (x1_q < x1_d);
            sy_d = (y1_q < y1_d);
            err_d = dx_d - dy_d;
          end else begin
            st_d = StDone;
          end
        end else begin
          err_d = err_q;
          if ((err_q <<< 1) > -dy_q) begin
            err_d = err_d - dy_q;
            x0_d = sx_q ? x0_q + 12'sd1 : x0_q - 12'sd1;
          end
          if ((err_q <<< 1) < dx_q) begin
            err_d = err_d + dx_q;
            y0_d = sy_q ? y0_q + 12'sd1 : y0_q - 12'sd1;
          end
        end
      end
      StRect: begin
        // Plots per index go top, bottom, left, right in turn, sequenced by oct_q.
        plot.valid = 1'b1;
        unique case (oct_q[1:0])
          2'd0: begin plot.x = x0_q + i_q; plot.y = y0_q; end
          2'd1: begin plot.x = x0_q + i_q; plot.y = y0_q + crd_t'(cur_q.h) - 12'sd1; end
          2'd2: begin plot.x = x0_q; plot.y = y0_q + i_q; end
          default: begin plot.x = x0_q + crd_t'(cur_q.w) - 12'sd1; plot.y = y0_q + i_q; end
        endcase
        if (!oct_q[1] && i_q >= crd_t'(cur_q.w)) plot.valid = 1'b0;
        if (oct_q[1] && i_q >= crd_t'(cur_q.h)) plot.valid = 1'b0;
        oct_d = {1'b0, oct_q[1:0] + 2'd1};
        if (oct_q[1:0] == 2'd3) begin
          i_d = i_q + 12'sd1;
          if (i_q + 12'sd1 >= crd_t'(cur_q.w) && i_q + 12'sd1 >= crd_t'(cur_q.h))
            st_d = StDone;
        end
      end
      StCircInit: begin
        cxo_d = '0; cyo_d = crd_t'(cur_q.r);
        dd_d = 12'sd3 - (crd_t'(cur_q.r) <<< 1);
        oct_d = 3'd0;
        st_d = StCircPlot;
      end
      StCircPlot: begin
        plot.valid = 1'b1;
        unique case (oct_q)
          3'd0: begin plot.x = x0_q + cxo_q; plot.y = y0_q + cyo_q; end
          3'd1: begin plot.x = x0_q - cxo_q; plot.y = y0_q + cyo_q; end
          3'd2: begin plot.x = x0_q + cxo_q; plot.y = y0_q - cyo_q; end
          3'd3: begin plot.x = x0_q - cxo_q; plot.y = y0_q - cyo_q; end
          3'd4: begin plot.x = x0_q + cyo_q; plot.y = y0_q + cxo_q; end
          3'd5: begin plot.x = x0_q - cyo_q; plot.y = y0_q + cxo_q; end
          3'd6: begin plot.x = x0_q + cyo_q; plot.y = y0_q - cxo_q; end
          default: begin plot.x = x0_q - cyo_q; plot.y = y0_q - cxo_q; end
        endcase
        oct_d = oct_q + 3'd1;
        if (oct_q == 3'd7) st_d = (cyo_q >= cxo_q) ? StCircStep : StDone;
      end
      StCircStep: begin
        cxo_d = cxo_q + 12'sd1;
        if (dd_q > 12'sd0) begin
          cyo_d = cyo_q - 12'sd1;
          dd_d = dd_q + ((cxo_q + 12'sd1 - cyo_q + 12'sd1) <<< 2) + 12'sd10;
        end else begin
          dd_d = dd_q + ((cxo_q + 12'sd1) <<< 2) + 12'sd6;
        end
        st_d = StCircPlot;
      end
      StRead: begin
        rd_ok_d = (cur_q.ax < 7'(CanvasWidth)) && (cur_q.ay < 5'(CanvasHeight));
        mem_a = AddrW'(cur_q.ay) * AddrW'(CanvasWidth) + AddrW'(cur_q.ax);
        st_d = StReadWait;
      end
      StReadWait: st_d = StDone;
      StDone: begin
        res_d = 1'b1;
        kind_d = cur_q.kind;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    if (plot.valid && plot.x >= 0 && plot.x < crd_t'(CanvasWidth)
        && plot.y >= 0 && plot.y < crd_t'(CanvasHeight)) begin
      mem_we = 1'b1; mem_wd = 1'b1;
      mem_a = AddrW'(plot.y) * AddrW'(CanvasWidth) + AddrW'(plot.x);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    if (st_q == StRead) rd_q <= mem[mem_a];
    cur_q <= cur_d;
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    dx_q <= dx_d; dy_q <= dy_d; err_q <= err_d; sx_q <= sx_d; sy_q <= sy_d;
    i_q <= i_d; cxo_q <= cxo_d; cyo_q <= cyo_d; dd_q <= dd_d;
    rd_ok_q <= rd_ok_d;
    kind_q <= kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      res_q <= 1'b0;
      pix_q <= 1'b0;
      seg_q <= 2'd0;
      oct_q <= 3'd0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      res_q <= res_d;
      pix_q <= (st_q == StDone) ? (cur_q.kind == KindRead && rd_ok_q && rd_q) : 1'b0;
      seg_q <= seg_d;
      oct_q <= (st_q == StIdle) ? 3'd0 : oct_d;
    end
  end

  // Reset runs one clearing sweep with no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b1;
    else if (st_q == StClear && clr_q == AddrW'(CanvasDepth - 1)) first_q <= 1'b0;
  end

`include "assert_macros.svh"
  `ASSERT_NEVER(a_pop_only_idle, clk_i, rst_ni, pop_o && st_q != StIdle)
  `ASSERT_IMPL(a_res_after_done, clk_i, rst_ni, !res_q || $past(st_q) == StDone)
  `ASSERT_NEVER(a_pix_only_read, clk_i, rst_ni, res_q && pix_q && kind_q != KindRead)
endmodule

/* rtl/outline_shape_rasterizer_top.sv */
// A clear writes every canvas cell in turn; lines plot pixel by pixel; rectangles plot a
// point on each side per index; circles one point per octant per step; reads fetch one cell.
// The pixel walker plots at most one pixel per cycle and takes a new request only when idle.
// After reset a sweep clears all 1920 canvas cells; two transfers may queue, then busy rises.
// A two-entry queue lets requests wait; the result strobe cannot be stalled.
// Depends on osr_pkg, osr_front and osr_back.
module outline_shape_rasterizer_top
  import osr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type_i,
  input  logic [6:0] point_a_x_i,
  input  logic [4:0] point_a_y_i,
  input  logic [6:0] point_b_x_i,
  input  logic [4:0] point_b_y_i,
  input  logic [6:0] point_c_x_i,
  input  logic [4:0] point_c_y_i,
  input  logic [6:0] span_width_i,
  input  logic [4:0] span_height_i,
  input  logic [6:0] circle_radius_i,
  output logic       done_o,
  output logic       pixel_value_o,
  output logic [2:0] served_kind_o
);
  req_t  req, head;
  logic  full, empty, pop;
  kind_e kind;

  always_comb begin
    req.kind = kind_e'(req_type_i);
    req.ax = point_a_x_i; req.ay = point_a_y_i;
    req.bx = point_b_x_i; req.by = point_b_y_i;
    req.cx = point_c_x_i; req.cy = point_c_y_i;
    req.w = span_width_i; req.h = span_height_i;
    req.r = circle_radius_i;
  end

  assign busy = full;

  osr_front u_front (
    .clk_i, .rst_ni, .push_i(start && !busy), .req_i(req), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  osr_back u_back (
    .clk_i, .rst_ni, .avail_i(!empty), .req_i(head), .pop_o(pop),
    .res_o(done_o), .pix_o(pixel_value_o), .kind_o(kind)
  );

  assign served_kind_o = 3'(kind);
endmodule
